[hw/rtl/qsbr_pkg.sv]
// qsbr_pkg: shared types and result kind codes for the queued sender bit receiver
// no dependencies; imported by the front, back, top level and checker
`default_nettype none

package qsbr_pkg;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_WELCOME = 2'd0;
  localparam kind_t KIND_BYTE    = 2'd1;
  localparam kind_t KIND_ACK     = 2'd2;
  localparam kind_t KIND_REFUSED = 2'd3;

  // control part of one queued command, the sender id travels beside it
  typedef struct packed {
    logic tick;
    logic bit_value;
  } cmd_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/qsbr_front.sv]
// qsbr_front: accepts input transfers, classifies them and holds them in a
// two-entry command queue for the back end; depends on qsbr_pkg
`default_nettype none

module qsbr_front import qsbr_pkg::*; #(
  parameter int ID_WIDTH = 22
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire logic                in_tick,
  input  wire logic                in_bit,
  input  wire logic [ID_WIDTH-1:0] in_id,
  output      logic                cmd_valid,
  input  wire logic                cmd_pop,
  output      cmd_ctl_t            cmd_ctl,
  output      logic [ID_WIDTH-1:0] cmd_id
);

  cmd_ctl_t            ctl_q [2];
  logic [ID_WIDTH-1:0] id_q  [2];
  logic                wr_ptr_r, wr_ptr_nxt;
  logic                rd_ptr_r, rd_ptr_nxt;
  logic [1:0]          cnt_r, cnt_nxt;
  logic                push;
  logic                pop;
  cmd_ctl_t            ctl_in;

  assign in_ready  = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign push      = in_valid && in_ready;
  assign pop       = cmd_pop && cmd_valid;
  assign cmd_ctl   = ctl_q[rd_ptr_r];
  assign cmd_id    = id_q[rd_ptr_r];

  // a tick carries no bit
  always_comb begin
    ctl_in.tick      = in_tick;
    ctl_in.bit_value = in_bit && !in_tick;
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ctl_q[wr_ptr_r] <= ctl_in;
      id_q[wr_ptr_r]  <= in_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/qsbr_back.sv]
// qsbr_back: executes queued commands against the sender queue memory,
// assembles bytes and drives the result register; depends on qsbr_pkg
`default_nettype none

module qsbr_back import qsbr_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_WIDTH    = 22
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cmd_valid,
  output      logic                cmd_pop,
  input  wire cmd_ctl_t            cmd_ctl,
  input  wire logic [ID_WIDTH-1:0] cmd_id,
  output      logic                res_valid,
  input  wire logic                res_ready,
  output      kind_t               res_kind,
  output      logic [ID_WIDTH-1:0] res_target,
  output      logic [7:0]          res_byte,
  output      logic                res_last
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W:0]   DEPTH_S  = (CNT_W+1)'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] FULL_C   = CNT_W'(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_SRD  = 3'd2;
  localparam logic [2:0] S_SCMP = 3'd3;
  localparam logic [2:0] S_NEW  = 3'd4;
  localparam logic [2:0] S_FRD  = 3'd5;
  localparam logic [2:0] S_FDAT = 3'd6;
  localparam logic [2:0] S_EMIT = 3'd7;

  function automatic logic [IDX_W-1:0] wrap_idx(input logic [CNT_W:0] s);
    logic [CNT_W:0] t;
    t = (s >= DEPTH_S) ? (s - DEPTH_S) : s;
    return t[IDX_W-1:0];
  endfunction

  logic [ID_WIDTH-1:0] mem [QUEUE_DEPTH];
  logic [ID_WIDTH-1:0] rdata_r;
  logic [IDX_W-1:0]    rd_addr;
  logic [IDX_W-1:0]    wr_addr;
  logic                mem_we;

  logic [2:0]          state_r, state_nxt;
  logic [IDX_W-1:0]    head_r, head_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [7:0]          shift_r, shift_nxt;
  logic [2:0]          bitc_r, bitc_nxt;
  logic [ID_WIDTH-1:0] head_id_r, head_id_nxt;
  logic [CNT_W-1:0]    scan_k_r, scan_k_nxt;

  logic                tick_r, tick_nxt;
  logic                bit_r, bit_nxt;
  logic [ID_WIDTH-1:0] id_r, id_nxt;

  kind_t               k0_r, k0_nxt;
  kind_t               k1_r, k1_nxt;
  logic [ID_WIDTH-1:0] t0_r, t0_nxt;
  logic [ID_WIDTH-1:0] t1_r, t1_nxt;
  logic [7:0]          b0_r, b0_nxt;
  logic                two_r, two_nxt;
  logic                eidx_r, eidx_nxt;

  logic                ov_r, ov_nxt;
  kind_t               ok_r, ok_nxt;
  logic [ID_WIDTH-1:0] ot_r, ot_nxt;
  logic [7:0]          ob_r, ob_nxt;
  logic                ol_r, ol_nxt;

  logic [IDX_W-1:0]    head_inc;
  logic [7:0]          byte_new;
  logic                head_hit;
  logic                load_ok;
  logic                emit_last;

  assign head_inc = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
  assign byte_new = shift_r | (8'(bit_r) << bitc_r);
  assign head_hit = (count_r != '0) && (head_id_r == id_r);
  assign load_ok  = !ov_r || res_ready;
  assign emit_last = eidx_r || !two_r;
  assign wr_addr  = wrap_idx((CNT_W+1)'(head_r) + (CNT_W+1)'(count_r));

  always_comb begin
    if (state_r == S_SRD) begin
      rd_addr = wrap_idx((CNT_W+1)'(head_r) + (CNT_W+1)'(scan_k_r));
    end else begin
      rd_addr = head_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= id_r;
    end
    rdata_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    count_nxt   = count_r;
    shift_nxt   = shift_r;
    bitc_nxt    = bitc_r;
    head_id_nxt = head_id_r;
    scan_k_nxt  = scan_k_r;
    tick_nxt    = tick_r;
    bit_nxt     = bit_r;
    id_nxt      = id_r;
    k0_nxt      = k0_r;
    k1_nxt      = k1_r;
    t0_nxt      = t0_r;
    t1_nxt      = t1_r;
    b0_nxt      = b0_r;
    two_nxt     = two_r;
    eidx_nxt    = eidx_r;
    ov_nxt      = ov_r && !res_ready;
    ok_nxt      = ok_r;
    ot_nxt      = ot_r;
    ob_nxt      = ob_r;
    ol_nxt      = ol_r;
    mem_we      = 1'b0;
    cmd_pop     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop   = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        b0_nxt   = '0;
        eidx_nxt = 1'b0;
        if (tick_r) begin
          shift_nxt = '0;
          bitc_nxt  = '0;
          state_nxt = S_IDLE;
          if (count_r != '0) begin
            head_nxt  = head_inc;
            count_nxt = count_r - 1'b1;
            if (count_r > CNT_W'(1)) begin
              // new head must be read before it can be acked
              k0_nxt    = KIND_ACK;
              two_nxt   = 1'b0;
              state_nxt = S_FRD;
            end
          end
        end else if (head_hit) begin
          if (bitc_r == 3'd7) begin
            k0_nxt    = KIND_BYTE;
            t0_nxt    = id_r;
            b0_nxt    = byte_new;
            shift_nxt = '0;
            bitc_nxt  = '0;
            k1_nxt    = KIND_ACK;
            if (byte_new == 8'd0) begin
              head_nxt  = head_inc;
              count_nxt = count_r - 1'b1;
              two_nxt   = (count_r > CNT_W'(1));
              state_nxt = (count_r > CNT_W'(1)) ? S_FRD : S_EMIT;
            end else begin
              t1_nxt    = head_id_r;
              two_nxt   = 1'b1;
              state_nxt = S_EMIT;
            end
          end else begin
            shift_nxt = byte_new;
            bitc_nxt  = bitc_r + 1'b1;
            k0_nxt    = KIND_ACK;
            t0_nxt    = head_id_r;
            two_nxt   = 1'b0;
            state_nxt = S_EMIT;
          end
        end else if (count_r > CNT_W'(1)) begin
          // head already compared, search the rest
          scan_k_nxt = CNT_W'(1);
          state_nxt  = S_SRD;
        end else begin
          state_nxt = S_NEW;
        end
      end
      S_SRD: begin
        state_nxt = S_SCMP;
      end
      S_SCMP: begin
        if (rdata_r == id_r) begin
          k0_nxt    = KIND_ACK;
          t0_nxt    = head_id_r;
          two_nxt   = 1'b0;
          state_nxt = S_EMIT;
        end else if (scan_k_r + 1'b1 == count_r) begin
          state_nxt = S_NEW;
        end else begin
          scan_k_nxt = scan_k_r + 1'b1;
          state_nxt  = S_SRD;
        end
      end
      S_NEW: begin
        state_nxt = S_EMIT;
        if (count_r == FULL_C) begin
          k0_nxt  = KIND_REFUSED;
          t0_nxt  = id_r;
          k1_nxt  = KIND_ACK;
          t1_nxt  = head_id_r;
          two_nxt = 1'b1;
        end else begin
          mem_we    = 1'b1;
          count_nxt = count_r + 1'b1;
          k0_nxt    = KIND_WELCOME;
          t0_nxt    = id_r;
          if (count_r == '0) begin
            head_id_nxt = id_r;
            k1_nxt      = KIND_ACK;
            t1_nxt      = id_r;
            two_nxt     = 1'b1;
          end else begin
            two_nxt = 1'b0;
          end
        end
      end
      S_FRD: begin
        state_nxt = S_FDAT;
      end
      S_FDAT: begin
        head_id_nxt = rdata_r;
        // the ack to the new head is always the final result
        if (two_r) begin
          t1_nxt = rdata_r;
        end else begin
          t0_nxt = rdata_r;
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (load_ok) begin
          ov_nxt = 1'b1;
          ok_nxt = eidx_r ? k1_r : k0_r;
          ot_nxt = eidx_r ? t1_r : t0_r;
          ob_nxt = eidx_r ? 8'd0 : b0_r;
          ol_nxt = emit_last;
          if (emit_last) begin
            eidx_nxt = 1'b0;
            if (cmd_valid) begin
              cmd_pop   = 1'b1;
              state_nxt = S_EXEC;
            end else begin
              state_nxt = S_IDLE;
            end
          end else begin
            eidx_nxt = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cmd_pop) begin
      tick_nxt = cmd_ctl.tick;
      bit_nxt  = cmd_ctl.bit_value;
      id_nxt   = cmd_id;
    end
  end

  always_ff @(posedge clk) begin
    tick_r    <= tick_nxt;
    bit_r     <= bit_nxt;
    id_r      <= id_nxt;
    head_id_r <= head_id_nxt;
    scan_k_r  <= scan_k_nxt;
    k0_r      <= k0_nxt;
    k1_r      <= k1_nxt;
    t0_r      <= t0_nxt;
    t1_r      <= t1_nxt;
    b0_r      <= b0_nxt;
    two_r     <= two_nxt;
    ok_r      <= ok_nxt;
    ot_r      <= ot_nxt;
    ob_r      <= ob_nxt;
    ol_r      <= ol_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      count_r <= '0;
      shift_r <= '0;
      bitc_r  <= '0;
      eidx_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      shift_r <= shift_nxt;
      bitc_r  <= bitc_nxt;
      eidx_r  <= eidx_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign res_valid  = ov_r;
  assign res_kind   = ok_r;
  assign res_target = ot_r;
  assign res_byte   = ob_r;
  assign res_last   = ol_r;

endmodule

`default_nettype wire

[hw/rtl/queued_sender_bit_receiver.sv]
// a transfer is queued in the front, popped into the back's command registers, executed and
// loaded into the result register; a search adds a memory read per queued entry, removing a
// head adds a read of the new head; the back takes its next command once its last result is
// loaded while the front queues two more; an item's results leave one per cycle unless stalled
// reset: synchronous active-low rst_n empties the sender queue and clears the partial byte;
// queue memory contents are not cleared
`default_nettype none

module queued_sender_bit_receiver import qsbr_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_WIDTH    = 22
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output      logic                                in_tready,
  // [ID_WIDTH-1:0] sender_id, [ID_WIDTH] bit_value, rest zero
  input  wire logic [((ID_WIDTH+1+7)/8)*8-1:0]     in_tdata,
  // [0] operation
  input  wire logic                                in_tuser,
  output      logic                                out_tvalid,
  input  wire logic                                out_tready,
  // [ID_WIDTH-1:0] target_id, [ID_WIDTH+7:ID_WIDTH] data_byte, rest zero
  output      logic [((ID_WIDTH+8+7)/8)*8-1:0]     out_tdata,
  // [1:0] kind
  output      logic [1:0]                          out_tuser,
  output      logic                                out_tlast
);

  localparam int OUT_DW = ((ID_WIDTH + 8 + 7) / 8) * 8;

  logic                cmd_valid;
  logic                cmd_pop;
  cmd_ctl_t            cmd_ctl;
  logic [ID_WIDTH-1:0] cmd_id;
  kind_t               res_kind;
  logic [ID_WIDTH-1:0] res_target;
  logic [7:0]          res_byte;

  qsbr_front #(
    .ID_WIDTH (ID_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_tick   (in_tuser),
    .in_bit    (in_tdata[ID_WIDTH]),
    .in_id     (in_tdata[ID_WIDTH-1:0]),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd_ctl   (cmd_ctl),
    .cmd_id    (cmd_id)
  );

  qsbr_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd_pop    (cmd_pop),
    .cmd_ctl    (cmd_ctl),
    .cmd_id     (cmd_id),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_kind   (res_kind),
    .res_target (res_target),
    .res_byte   (res_byte),
    .res_last   (out_tlast)
  );

  assign out_tuser = res_kind;
  assign out_tdata = OUT_DW'({res_byte, res_target});

endmodule

`default_nettype wire

[hw/rtl/qsbr_checker.sv]
// qsbr_checker: port-level assertions on the result channel, bound to the top level
// depends on qsbr_pkg and queued_sender_bit_receiver
`default_nettype none

module qsbr_checker import qsbr_pkg::*; #(
  parameter int ID_WIDTH = 22
) (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [((ID_WIDTH+8+7)/8)*8-1:0] out_tdata,
  input wire logic [1:0]                      out_tuser,
  input wire logic                            out_tlast
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  a_ack_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_ACK |-> out_tlast)
    else $error("ack not final result of its item");

  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_BYTE |-> out_tdata[ID_WIDTH +: 8] == 8'd0)
    else $error("data byte set on non-byte result");

  a_refuse_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tuser == KIND_REFUSED |=>
      out_tvalid && out_tuser == KIND_ACK)
    else $error("refusal not followed by ack");

endmodule

bind queued_sender_bit_receiver qsbr_checker #(
  .ID_WIDTH (ID_WIDTH)
) u_qsbr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

[tb/queued_sender_bit_receiver_tb.sv]
// testbench for queued_sender_bit_receiver: scoreboard class with its own sender queue predictor
// depends on qsbr_pkg and the queued_sender_bit_receiver top level only
`timescale 1ns / 1ps

localparam logic OP_BIT  = 1'b0;
localparam logic OP_TICK = 1'b1;

class reply_scoreboard #(int DEPTH = 16, int IDW = 22);
  typedef struct packed {
    qsbr_pkg::kind_t  kind;
    logic [IDW-1:0]   target;
    logic [7:0]       data;
    logic             last;
  } reply_t;

  logic [IDW-1:0] roster[$];
  logic [7:0]     partial_byte;
  int unsigned    partial_bits;
  reply_t         due_replies[$];
  int unsigned    errors, events, ticks, replies;
  int unsigned    by_kind[4];
  int unsigned    full_hits;

  function new();
    partial_byte = '0;
    partial_bits = 0;
    errors = 0;
    events = 0;
    ticks = 0;
    replies = 0;
    full_hits = 0;
    foreach (by_kind[k]) by_kind[k] = 0;
  endfunction

  function void flag(string msg);
    errors++;
    if (errors <= 10) $display("mismatch: %s", msg);
  endfunction

  function void push(qsbr_pkg::kind_t kind, logic [IDW-1:0] target, logic [7:0] data);
    reply_t r;
    r.kind = kind;
    r.target = target;
    r.data = data;
    r.last = 1'b0;
    due_replies.push_back(r);
  endfunction

  // one accepted input transfer: update the queue model and queue up its replies
  function void take_event(logic op, logic [IDW-1:0] id, logic bv);
    int unsigned start_n;
    bit known;
    start_n = due_replies.size();
    known = 0;
    events++;
    if (op == OP_TICK) begin
      ticks++;
      if (roster.size() > 0) void'(roster.pop_front());
      partial_byte = '0;
      partial_bits = 0;
      if (roster.size() > 0) push(qsbr_pkg::KIND_ACK, roster[0], 8'h00);
    end else if (roster.size() > 0 && roster[0] == id) begin
      partial_byte[partial_bits] = bv;
      if (partial_bits == 7) begin
        push(qsbr_pkg::KIND_BYTE, id, partial_byte);
        // an all-zero byte ends the head sender's turn
        if (partial_byte == 8'h00) void'(roster.pop_front());
        partial_byte = '0;
        partial_bits = 0;
      end else begin
        partial_bits++;
      end
      if (roster.size() > 0) push(qsbr_pkg::KIND_ACK, roster[0], 8'h00);
    end else begin
      foreach (roster[k]) if (roster[k] == id) known = 1;
      if (known) begin
        push(qsbr_pkg::KIND_ACK, roster[0], 8'h00);
      end else if (roster.size() >= DEPTH) begin
        full_hits++;
        push(qsbr_pkg::KIND_REFUSED, id, 8'h00);
        push(qsbr_pkg::KIND_ACK, roster[0], 8'h00);
      end else begin
        roster.push_back(id);
        push(qsbr_pkg::KIND_WELCOME, id, 8'h00);
        if (roster.size() == 1) push(qsbr_pkg::KIND_ACK, id, 8'h00);
      end
    end
    if (due_replies.size() > start_n) due_replies[due_replies.size()-1].last = 1'b1;
  endfunction

  function void check_reply(qsbr_pkg::kind_t kind, logic [IDW-1:0] target, logic [7:0] data,
                            logic last);
    reply_t want;
    replies++;
    if (due_replies.size() == 0) begin
      flag($sformatf("unexpected reply kind %0d target %06h data %02h last %0b",
                     kind, target, data, last));
      return;
    end
    want = due_replies.pop_front();
    by_kind[want.kind]++;
    if (kind !== want.kind || target !== want.target || data !== want.data ||
        last !== want.last)
      flag($sformatf({"reply %0d: expected kind %0d target %06h data %02h last %0b, ",
                      "got kind %0d target %06h data %02h last %0b"},
                     replies, want.kind, want.target, want.data, want.last,
                     kind, target, data, last));
  endfunction
endclass

module queued_sender_bit_receiver_tb;
  import qsbr_pkg::*;

  localparam int QDEPTH        = 16;
  localparam int IDW           = 22;
  localparam int IN_W          = ((IDW + 1 + 7) / 8) * 8;
  localparam int OUT_W         = ((IDW + 8 + 7) / 8) * 8;
  localparam int ID_MAX        = (1 << IDW) - 1;
  localparam int RANDOM_ITEMS  = 1525;
  // worst case: full search plus head removal, with margin
  localparam int SETTLE_CYCLES = 60;
  localparam int LIMIT         = 1000000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             in_tuser = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic [1:0]       out_tuser;
  logic             out_tlast;

  reply_scoreboard #(.DEPTH(QDEPTH), .IDW(IDW)) sb;

  int unsigned cycles = 0;
  int unsigned ready_left = 0;
  int unsigned ready_mode = 0;

  queued_sender_bit_receiver #(
    .QUEUE_DEPTH(QDEPTH),
    .ID_WIDTH   (IDW)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles == LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // monitors: both channels sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.take_event(in_tuser, in_tdata[IDW-1:0], in_tdata[IDW]);
      if (out_tvalid && out_tready)
        sb.check_reply(out_tuser, out_tdata[IDW-1:0], out_tdata[IDW+7:IDW], out_tlast);
    end
  end

  // receiver stall pattern: modes of random length, from always ready to long stalls
  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_left = $urandom_range(20, 200);
    end
    ready_left = ready_left - 1;
    case (ready_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= ((ready_left % 8) < 5);
    endcase
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_event(input logic op, input logic [IDW-1:0] id, input logic bv);
    in_tuser  <= op;
    in_tdata  <= {{(IN_W-IDW-1){1'b0}}, bv, id};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // hold the sender until every expected reply has arrived and the block is quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.due_replies.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic random_run(input int unsigned total);
    int unsigned sent, burst_left, phase_left, profile, roll, hw, nw, kw, qn;
    logic op, bv;
    logic [IDW-1:0] id;
    bit zero_byte;
    burst_left = 0;
    phase_left = 0;
    profile = 0;
    zero_byte = 0;
    for (sent = 0; sent < total; sent++) begin
      // phases: normal traffic, filling the queue, draining it
      if (phase_left == 0) begin
        profile = $urandom_range(0, 2);
        phase_left = $urandom_range(30, 120);
      end
      phase_left--;
      if (sent % 400 == 399) settle();
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) begin
          in_tvalid <= 1'b0;
          repeat ($urandom_range(1, 7)) @(negedge clk);
        end
      end
      burst_left--;
      case (profile)
        0: begin hw = 60; nw = 15; kw = 12; end
        1: begin hw = 30; nw = 50; kw = 12; end
        default: begin hw = 55; nw = 10; kw = 10; end
      endcase
      qn = sb.roster.size();
      if (sb.partial_bits == 0) zero_byte = ($urandom_range(0, 4) == 0);
      op = OP_BIT;
      bv = 1'($urandom_range(0, 1));
      id = IDW'($urandom_range(0, ID_MAX));
      roll = $urandom_range(0, 99);
      if (roll < hw) begin
        // well-formed byte from the head, otherwise a new sender
        if (qn > 0) begin
          id = sb.roster[0];
          if (zero_byte) bv = 1'b0;
        end
      end else if (roll < hw + nw) begin
        if ($urandom_range(0, 7) == 0) id = IDW'($urandom_range(0, 7));
      end else if (roll < hw + nw + kw) begin
        if (qn > 1) id = sb.roster[$urandom_range(1, qn - 1)];
        else if (qn == 1) id = sb.roster[0];
      end else begin
        op = OP_TICK;
      end
      send_event(op, id, bv);
    end
  endtask

  initial begin
    logic [7:0] first_byte;
    int k;
    first_byte = 8'h4D;
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // tick on an empty queue, ignored fields set
    send_event(OP_TICK, IDW'(ID_MAX), 1'b1);
    // first sender into an empty queue: welcome and ack
    send_event(OP_BIT, '0, 1'b1);
    for (k = 0; k < 8; k++) send_event(OP_BIT, '0, first_byte[k]);
    // second sender: welcome only, then a repeat from it is a known non-head
    send_event(OP_BIT, IDW'(ID_MAX), 1'b0);
    send_event(OP_BIT, IDW'(ID_MAX), 1'b1);
    send_event(OP_BIT, IDW'(22'h2AAAAA), 1'b1);
    // zero byte removes the head
    for (k = 0; k < 8; k++) send_event(OP_BIT, '0, 1'b0);
    // partial byte dropped by a tick, then a second tick that removes the next head
    send_event(OP_BIT, IDW'(ID_MAX), 1'b1);
    send_event(OP_BIT, IDW'(ID_MAX), 1'b1);
    send_event(OP_TICK, IDW'(22'h155555), 1'b0);
    send_event(OP_TICK, '0, 1'b0);
    settle();

    random_run(RANDOM_ITEMS);
    settle();

    $display("covered %0d input transfers (%0d silence ticks, %0d hits on a full queue)",
             sb.events, sb.ticks, sb.full_hits);
    $display("checked %0d replies: %0d welcomes, %0d bytes, %0d acks, %0d refusals; %0d errors",
             sb.replies, sb.by_kind[KIND_WELCOME], sb.by_kind[KIND_BYTE],
             sb.by_kind[KIND_ACK], sb.by_kind[KIND_REFUSED], sb.errors);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

[filelist.f]
hw/rtl/qsbr_pkg.sv
hw/rtl/qsbr_front.sv
hw/rtl/qsbr_back.sv
hw/rtl/queued_sender_bit_receiver.sv
hw/rtl/qsbr_checker.sv
tb/queued_sender_bit_receiver_tb.sv
